// File: src/urq_pkg.sv
// Shared types and constants for the UART receive event queue.
// No dependencies; imported by every module of the block.
package urq_pkg;

  // Default number of physical queue slots
  localparam int QUEUE_DEPTH_DEF = 256;

  // Width of the depth register word on the config port
  localparam int CFG_W = 9;
  // Depth register value after reset, before clamping
  localparam int DEPTH_RST = 256;

  // Received word layout
  localparam int RX_W        = 12;
  localparam int BIT_FRAMING = 8;
  localparam int BIT_PARITY  = 9;
  localparam int BIT_OVERRUN = 10;
  localparam int BIT_BREAK   = 11;

  // Error codes carried in the event value
  localparam logic [7:0] CODE_FRAMING = 8'd0;
  localparam logic [7:0] CODE_OVERRUN = 8'd1;
  localparam logic [7:0] CODE_PARITY  = 8'd2;
  localparam logic [7:0] CODE_BREAK   = 8'd3;

  // Event kinds
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Pending-event mask positions, in push order
  localparam int EV_OVERRUN = 0;
  localparam int EV_FRAME   = 1;  // break or framing
  localparam int EV_PARITY  = 2;
  localparam int EV_CHAR    = 3;
  localparam int EV_N       = 4;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_POP_DATA
  } state_e;

  // One queue entry
  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } event_t;

endpackage

// File: src/urq_step.sv
// Shared index advance unit: next slot with wrap at the depth in use,
// plus a compare against the other index. Depends on urq_pkg.
module urq_step #(
  parameter int QUEUE_DEPTH = urq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   idx_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] depth_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   cmp_i,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   next_o,
  output logic                             hit_o
);
  import urq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int DEP_W = $clog2(QUEUE_DEPTH + 1);

  logic [DEP_W-1:0] inc;

  // Increment, wrap to zero at the end of the slots in use
  always_comb begin
    inc = DEP_W'(idx_i) + DEP_W'(1);
    if (inc >= depth_i) begin
      next_o = '0;
    end else begin
      next_o = inc[IDX_W-1:0];
    end
    hit_o = (next_o == cmp_i);
  end

endmodule

// File: src/urq_store.sv
// Event store: one write port, one registered read port.
// Contents undefined until written. Depends on urq_pkg.
module urq_store #(
  parameter int QUEUE_DEPTH = urq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr_i,
  input  urq_pkg::event_t                wdata_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr_i,
  output urq_pkg::event_t                rdata_o
);
  import urq_pkg::*;

  event_t mem [QUEUE_DEPTH];
  event_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/urq_seq.sv
// Sequencer: depth register, queue indices, pending-event mask and the
// result word. Drives the shared step unit and the store. Depends on urq_pkg.
module urq_seq #(
  parameter int QUEUE_DEPTH = urq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode_i,
  input  logic [urq_pkg::RX_W-1:0]         rx_word_i,
  // config
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [urq_pkg::CFG_W-1:0]        cfg_data_i,
  // step unit
  output logic [$clog2(QUEUE_DEPTH)-1:0]   step_idx_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] step_depth_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   step_cmp_o,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   step_next_i,
  input  logic                             step_hit_i,
  // store
  output logic                             mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_waddr_o,
  output urq_pkg::event_t                  mem_wdata_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_raddr_o,
  input  urq_pkg::event_t                  mem_rdata_i,
  // result
  output logic                             done_o,
  output logic                             pop_valid_o,
  output logic                             pop_kind_o,
  output logic [7:0]                       pop_value_o,
  output logic [1:0]                       pushed_count_o,
  output logic [1:0]                       dropped_count_o
);
  import urq_pkg::*;

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int DEP_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W     = (DEP_W > CFG_W) ? DEP_W : CFG_W;
  localparam int RST_DEPTH = (QUEUE_DEPTH < DEPTH_RST) ? QUEUE_DEPTH : DEPTH_RST;

  state_e           state_q, state_d;
  logic [DEP_W-1:0] depth_q, depth_d;
  logic [IDX_W-1:0] rd_q, rd_d;
  logic [IDX_W-1:0] wr_q, wr_d;
  logic [EV_N-1:0]  mask_q, mask_d;
  logic [EV_N-1:0]  mask_rest;
  logic [RX_W-1:0]  word_q, word_d;
  logic [1:0]       npush_q, npush_d;
  logic [1:0]       ndrop_q, ndrop_d;
  logic             done_q, done_d;

  // result payload
  logic             res_valid_q, res_valid_d;
  logic             res_kind_q, res_kind_d;
  logic [7:0]       res_value_q, res_value_d;
  logic [1:0]       res_push_q, res_push_d;
  logic [1:0]       res_drop_q, res_drop_d;
  logic             res_load;

  event_t           ev_cur;
  logic [CMP_W-1:0] cfg_ext;
  logic [DEP_W-1:0] cfg_clamped;
  logic             accept;
  logic             cfg_wr;

  assign accept      = start && (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign busy        = (state_q != ST_IDLE);

  // Clamp a depth write to the legal slot range
  always_comb begin
    cfg_ext = CMP_W'(cfg_data_i);
    if (cfg_ext < CMP_W'(2)) begin
      cfg_clamped = DEP_W'(2);
    end else if (cfg_ext > CMP_W'(QUEUE_DEPTH)) begin
      cfg_clamped = DEP_W'(QUEUE_DEPTH);
    end else begin
      cfg_clamped = cfg_ext[DEP_W-1:0];
    end
  end

  // Event selected by the lowest pending mask bit
  always_comb begin
    ev_cur.kind  = KIND_ERROR;
    ev_cur.value = CODE_PARITY;
    if (mask_q[EV_OVERRUN]) begin
      ev_cur.value = CODE_OVERRUN;
    end else if (mask_q[EV_FRAME]) begin
      ev_cur.value = word_q[BIT_BREAK] ? CODE_BREAK : CODE_FRAMING;
    end else if (mask_q[EV_PARITY]) begin
      ev_cur.value = CODE_PARITY;
    end else begin
      ev_cur.kind  = KIND_CHAR;
      ev_cur.value = word_q[7:0];
    end
    mask_rest = mask_q & (mask_q - EV_N'(1));
  end

  // Step unit and store hookup
  assign step_idx_o   = (state_q == ST_POP_DATA) ? rd_q : wr_q;
  assign step_depth_o = depth_q;
  assign step_cmp_o   = rd_q;
  assign mem_waddr_o  = wr_q;
  assign mem_wdata_o  = ev_cur;
  assign mem_raddr_o  = rd_q;

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    mask_d      = mask_q;
    word_d      = word_q;
    npush_d     = npush_q;
    ndrop_d     = ndrop_q;
    done_d      = 1'b0;
    mem_we_o    = 1'b0;
    res_load    = 1'b0;
    res_valid_d = 1'b0;
    res_kind_d  = 1'b0;
    res_value_d = '0;
    res_push_d  = 2'd0;
    res_drop_d  = 2'd0;

    case (state_q)
      ST_IDLE: begin
        if (cfg_wr) begin
          depth_d = cfg_clamped;
          rd_d    = '0;
          wr_d    = '0;
        end
        if (accept) begin
          word_d  = rx_word_i;
          npush_d = 2'd0;
          ndrop_d = 2'd0;
          mask_d[EV_OVERRUN] = rx_word_i[BIT_OVERRUN];
          mask_d[EV_FRAME]   = rx_word_i[BIT_BREAK] | rx_word_i[BIT_FRAMING];
          mask_d[EV_PARITY]  = rx_word_i[BIT_PARITY];
          mask_d[EV_CHAR]    = (rx_word_i[BIT_BREAK:BIT_FRAMING] == '0);
          state_d = (op_e'(opcode_i) == OP_POP) ? ST_POP : ST_PUSH;
        end
      end

      // One pending event per cycle; drop when the next slot is the read slot
      ST_PUSH: begin
        if (step_hit_i) begin
          ndrop_d = ndrop_q + 2'd1;
        end else begin
          mem_we_o = 1'b1;
          wr_d     = step_next_i;
          npush_d  = npush_q + 2'd1;
        end
        mask_d = mask_rest;
        if (mask_rest == '0) begin
          done_d     = 1'b1;
          res_load   = 1'b1;
          res_push_d = npush_d;
          res_drop_d = ndrop_d;
          state_d    = ST_IDLE;
        end
      end

      // Empty check; the read of the head slot is issued this cycle
      ST_POP: begin
        if (rd_q == wr_q) begin
          done_d   = 1'b1;
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_POP_DATA;
        end
      end

      ST_POP_DATA: begin
        rd_d        = step_next_i;
        done_d      = 1'b1;
        res_load    = 1'b1;
        res_valid_d = 1'b1;
        res_kind_d  = mem_rdata_i.kind;
        res_value_d = mem_rdata_i.value;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      depth_q <= DEP_W'(RST_DEPTH);
      rd_q    <= '0;
      wr_q    <= '0;
      mask_q  <= '0;
      npush_q <= 2'd0;
      ndrop_q <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      mask_q  <= mask_d;
      npush_q <= npush_d;
      ndrop_q <= ndrop_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (res_load) begin
      res_valid_q <= res_valid_d;
      res_kind_q  <= res_kind_d;
      res_value_q <= res_value_d;
      res_push_q  <= res_push_d;
      res_drop_q  <= res_drop_d;
    end
  end

  assign done_o          = done_q;
  assign pop_valid_o     = res_valid_q;
  assign pop_kind_o      = res_kind_q;
  assign pop_value_o     = res_value_q;
  assign pushed_count_o  = res_push_q;
  assign dropped_count_o = res_drop_q;

  // Indices always stay inside the slots in use
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DEP_W'(rd_q) < depth_q) && (DEP_W'(wr_q) < depth_q))
    else $error("queue index beyond depth in use");

  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  // A popped event never comes with push counts
  a_pop_no_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_valid_q) |-> (res_push_q == 2'd0 && res_drop_q == 2'd0))
    else $error("pop result carries push counts");

  // Push sequencing always has an event pending
  a_push_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (mask_q != '0))
    else $error("push step with no pending event");

  // An accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command accepted but block not busy");

endmodule

// File: src/uart_receive_event_queue.sv
// Top level of the UART receive event queue.
// Instantiates urq_seq, urq_step and urq_store; depends on urq_pkg.
//
// Usage:
//   Command channel: a word (opcode_i, rx_word_i) is taken at a clock edge
//   where start is high and busy is low. Opcode push splits rx_word_i into
//   error events (overrun, break or framing, parity) or one character event
//   and writes them to a circular queue that keeps one slot free; writes to
//   a full queue are dropped and counted. Opcode pop returns the oldest event.
//   Result channel: done_o is high for exactly one cycle with the result word
//   on the pop_* and *_count ports. The receiver cannot stall; the result is
//   taken at the edge that ends the strobe cycle.
//   Sequencing: push writes each pending event in turn, or drops it when the
//   queue is full; pop checks for empty and otherwise reads the head slot
//   (store read is registered). done_o rises the cycle after the last step.
//   A new command may start in the strobe cycle; commands run one at a time,
//   set by the single store write port shared through one index-advance unit.
//   Config channel: cfg_data_i is the slots-in-use value (clamped to 2 ..
//   QUEUE_DEPTH), written when cfg_valid_i and cfg_ready_o are high; ready is
//   high while idle. A write empties the queue.
//   Reset: queue empty, depth in use min(256, QUEUE_DEPTH); store contents
//   are not cleared, so no reset pass is needed.
module uart_receive_event_queue #(
  parameter int QUEUE_DEPTH = urq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode_i,
  input  logic [urq_pkg::RX_W-1:0]  rx_word_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [urq_pkg::CFG_W-1:0] cfg_data_i,
  output logic                      done_o,
  output logic                      pop_valid_o,
  output logic                      pop_kind_o,
  output logic [7:0]                pop_value_o,
  output logic [1:0]                pushed_count_o,
  output logic [1:0]                dropped_count_o
);
  import urq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int DEP_W = $clog2(QUEUE_DEPTH + 1);

  logic [IDX_W-1:0] step_idx;
  logic [DEP_W-1:0] step_depth;
  logic [IDX_W-1:0] step_cmp;
  logic [IDX_W-1:0] step_next;
  logic             step_hit;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  event_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  event_t           mem_rdata;

  // Sequencer
  urq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .rx_word_i       (rx_word_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .step_idx_o      (step_idx),
    .step_depth_o    (step_depth),
    .step_cmp_o      (step_cmp),
    .step_next_i     (step_next),
    .step_hit_i      (step_hit),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .done_o          (done_o),
    .pop_valid_o     (pop_valid_o),
    .pop_kind_o      (pop_kind_o),
    .pop_value_o     (pop_value_o),
    .pushed_count_o  (pushed_count_o),
    .dropped_count_o (dropped_count_o)
  );

  // Shared index advance unit
  urq_step #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_step (
    .idx_i   (step_idx),
    .depth_i (step_depth),
    .cmp_i   (step_cmp),
    .next_o  (step_next),
    .hit_o   (step_hit)
  );

  // Event store
  urq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: bench/uart_receive_event_queue_tb.sv
// Testbench for uart_receive_event_queue: directed and random receive/pop words
// with depth register writes, checked against an in-bench queue predictor.
// Depends on urq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module uart_receive_event_queue_tb;
  import urq_pkg::*;

  localparam int QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int CALM_TAIL   = 40;

  typedef enum logic [1:0] {
    IT_CMD,
    IT_CFG,
    IT_DRAIN
  } item_kind_e;

  typedef struct {
    item_kind_e       kind;
    op_e              op;
    logic [RX_W-1:0]  word;
    logic [CFG_W-1:0] depth;
  } stim_item_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] value;
    logic [1:0] pushed;
    logic [1:0] dropped;
  } rx_result_t;

  // DUT connections; the driven inputs are known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  logic             opcode_i    = OP_PUSH;
  logic [RX_W-1:0]  rx_word_i   = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             done_o;
  logic             pop_valid_o;
  logic             pop_kind_o;
  logic [7:0]       pop_value_o;
  logic [1:0]       pushed_count_o;
  logic [1:0]       dropped_count_o;

  uart_receive_event_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .rx_word_i      (rx_word_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .pop_valid_o    (pop_valid_o),
    .pop_kind_o     (pop_kind_o),
    .pop_value_o    (pop_value_o),
    .pushed_count_o (pushed_count_o),
    .dropped_count_o(dropped_count_o)
  );

  // Stimulus and expected results
  stim_item_t pending_words[$];
  rx_result_t expected_events[$];
  int         issued_cnt   = 0;
  int         done_cnt     = 0;
  int         mismatch_cnt = 0;

  // Queue predictor state
  event_t     ev_store[QDEPTH];
  int         ev_depth = (QDEPTH < DEPTH_RST) ? QDEPTH : DEPTH_RST;
  int         ev_rd    = 0;
  int         ev_wr    = 0;

  // Driver working variables
  bit         take_next;
  bit         nxt_start;
  bit         nxt_cfg;
  bit         calm_run = 1'b0;
  int         gap_left = 0;
  stim_item_t cur;

  // Watchdog
  int         stall_cycles = 0;
  rx_result_t want;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Depth write: clamp to 2 .. QDEPTH and empty the queue
  function automatic void set_depth(input logic [CFG_W-1:0] v);
    if (v < 2) ev_depth = 2;
    else if (v > QDEPTH) ev_depth = QDEPTH;
    else ev_depth = v;
    ev_rd = 0;
    ev_wr = 0;
  endfunction

  // One slot stays free; a push into a full queue is lost
  function automatic bit store_event(input logic kind, input logic [7:0] value);
    int nxt;
    nxt = ev_wr + 1;
    if (nxt >= ev_depth) nxt = 0;
    if (nxt == ev_rd) return 1'b0;
    ev_store[ev_wr] = '{kind: kind, value: value};
    ev_wr = nxt;
    return 1'b1;
  endfunction

  function automatic void tally(inout rx_result_t r, input bit stored);
    if (stored) r.pushed++;
    else r.dropped++;
  endfunction

  // Expected result of one command word; advances the predictor
  function automatic rx_result_t predict_rx_event(input op_e op, input logic [RX_W-1:0] word);
    rx_result_t r;
    r = '0;
    if (op == OP_PUSH) begin
      if (word[BIT_OVERRUN]) tally(r, store_event(KIND_ERROR, CODE_OVERRUN));
      // break hides framing
      if (word[BIT_BREAK]) tally(r, store_event(KIND_ERROR, CODE_BREAK));
      else if (word[BIT_FRAMING]) tally(r, store_event(KIND_ERROR, CODE_FRAMING));
      if (word[BIT_PARITY]) tally(r, store_event(KIND_ERROR, CODE_PARITY));
      if (!word[BIT_OVERRUN] && !word[BIT_BREAK] && !word[BIT_FRAMING] && !word[BIT_PARITY])
        tally(r, store_event(KIND_CHAR, word[7:0]));
    end else if (ev_rd != ev_wr) begin
      r.valid = 1'b1;
      r.kind  = ev_store[ev_rd].kind;
      r.value = ev_store[ev_rd].value;
      ev_rd++;
      if (ev_rd >= ev_depth) ev_rd = 0;
    end
    return r;
  endfunction

  task automatic add_cmd(input op_e op, input logic [RX_W-1:0] word);
    pending_words.push_back('{kind: IT_CMD, op: op, word: word, depth: '0});
  endtask

  task automatic add_cfg(input logic [CFG_W-1:0] depth);
    pending_words.push_back('{kind: IT_CFG, op: OP_PUSH, word: '0, depth: depth});
  endtask

  task automatic add_drain();
    pending_words.push_back('{kind: IT_DRAIN, op: OP_PUSH, word: '0, depth: '0});
  endtask

  function automatic logic [RX_W-1:0] err_bit(input int pos);
    return RX_W'(1) << pos;
  endfunction

  // About one word in three a clean character, the rest with random error bits
  function automatic logic [RX_W-1:0] rand_rx_word();
    logic [3:0] errs;
    errs = ($urandom_range(0, 2) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
    return {errs, 8'($urandom)};
  endfunction

  // Driver: one command or depth write in flight, held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_left    = 0;
    end else begin
      take_next = 1'b1;
      if (start) begin
        if (!busy) begin
          expected_events.push_back(predict_rx_event(op_e'(opcode_i), rx_word_i));
          issued_cnt <= issued_cnt + 1;
        end else begin
          take_next = 1'b0;
        end
      end
      if (cfg_valid_i) begin
        if (cfg_ready_o) set_depth(cfg_data_i);
        else take_next = 1'b0;
      end
      if (take_next) begin
        nxt_start = 1'b0;
        nxt_cfg   = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          cur = pending_words[0];
          case (cur.kind)
            IT_CMD: begin
              nxt_start = 1'b1;
              opcode_i  <= cur.op;
              rx_word_i <= cur.word;
              void'(pending_words.pop_front());
              if ($urandom_range(0, 24) == 0) calm_run = !calm_run;
              if (!calm_run && pending_words.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
                gap_left = $urandom_range(1, 3);
            end
            // write the depth only once the block has gone idle
            IT_CFG: begin
              if (!start && issued_cnt == done_cnt) begin
                nxt_cfg = 1'b1;
                cfg_data_i <= cur.depth;
                void'(pending_words.pop_front());
              end
            end
            default: begin
              if (!start && issued_cnt == done_cnt) void'(pending_words.pop_front());
            end
          endcase
        end
        start       <= nxt_start;
        cfg_valid_i <= nxt_cfg;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        done_cnt <= done_cnt + 1;
        if (done_cnt >= issued_cnt) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_events[done_cnt];
          if (pop_valid_o !== want.valid)
            report_mismatch($sformatf("word %0d pop_valid %b, want %b",
                                      done_cnt, pop_valid_o, want.valid));
          if (pop_kind_o !== want.kind)
            report_mismatch($sformatf("word %0d pop_kind %b, want %b",
                                      done_cnt, pop_kind_o, want.kind));
          if (pop_value_o !== want.value)
            report_mismatch($sformatf("word %0d pop_value %h, want %h",
                                      done_cnt, pop_value_o, want.value));
          if (pushed_count_o !== want.pushed)
            report_mismatch($sformatf("word %0d pushed_count %0d, want %0d",
                                      done_cnt, pushed_count_o, want.pushed));
          if (dropped_count_o !== want.dropped)
            report_mismatch($sformatf("word %0d dropped_count %0d, want %0d",
                                      done_cnt, dropped_count_o, want.dropped));
        end
      end
      // watchdog on handshake progress
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int depth_pick[9];
    int ph;
    int i;
    int push_pct;

    depth_pick = '{0, 1, 2, 3, 5, 17, 255, 257, 511};

    // Directed: pop from empty, each event kind, char extremes
    add_cmd(OP_POP, 12'hFFF);
    add_cmd(OP_PUSH, 12'h000);
    add_cmd(OP_PUSH, 12'h0FF);
    add_cmd(OP_PUSH, err_bit(BIT_FRAMING) | 12'h055);
    add_cmd(OP_PUSH, err_bit(BIT_PARITY));
    add_cmd(OP_PUSH, err_bit(BIT_OVERRUN) | 12'h0FF);
    add_cmd(OP_PUSH, err_bit(BIT_BREAK));
    add_cmd(OP_PUSH, err_bit(BIT_BREAK) | err_bit(BIT_FRAMING));
    add_cmd(OP_PUSH, 12'hFA5);
    add_cmd(OP_PUSH, err_bit(BIT_OVERRUN) | err_bit(BIT_FRAMING) | err_bit(BIT_PARITY));
    for (i = 0; i < 14; i++) add_cmd(OP_POP, 12'h000);
    // smallest queue holds one event
    add_cfg(9'd0);
    add_cmd(OP_PUSH, 12'hF00);
    add_cmd(OP_PUSH, 12'h041);
    add_cmd(OP_POP, 12'h000);
    add_cmd(OP_POP, 12'h000);

    // Fill the full-size queue past capacity, then pause and pop 20 events
    add_cfg(9'(QDEPTH));
    for (i = 0; i < 90; i++) add_cmd(OP_PUSH, {4'hF, 8'($urandom)});
    add_drain();
    for (i = 0; i < 20; i++) add_cmd(OP_POP, 12'($urandom));

    // Random phases over several depths, push-heavy or pop-heavy
    for (ph = 0; ph < 10; ph++) begin
      if (ph < 9) add_cfg(9'(depth_pick[ph]));
      else add_cfg(9'($urandom_range(0, 511)));
      push_pct = $urandom_range(30, 80);
      for (i = 0; i < 28; i++) begin
        if ($urandom_range(0, 99) < push_pct) add_cmd(OP_PUSH, rand_rx_word());
        else add_cmd(OP_POP, 12'($urandom));
        if ($urandom_range(0, 59) == 0) add_drain();
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_words.size() != 0 || start || cfg_valid_i || done_cnt < issued_cnt);
    repeat (8) @(posedge clk_i);
    if (done_cnt < issued_cnt)
      report_mismatch($sformatf("%0d results never arrived", issued_cnt - done_cnt));

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
